// ===== rtl/core/integer_combinatorics_unit_assert.svh =====
// assertion macros for the integer combinatorics unit checker
`ifndef INTEGER_COMBINATORICS_UNIT_ASSERT_SVH
`define INTEGER_COMBINATORICS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, muted during reset
`define ICU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, muted during reset
`define ICU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/icu_pkg.sv =====
// shared types, constants and lookup tables of the integer combinatorics unit
package icu_pkg;

    localparam int DATA_W = 64;
    localparam int ARG_W  = 6;
    localparam int CNT_W  = 6;

    localparam logic [ARG_W-1:0] MAX_FACTORIAL_ARG        = 6'd20;
    localparam logic [ARG_W-1:0] MAX_DOUBLE_FACTORIAL_ARG = 6'd33;

    // largest exact result: 33!!
    localparam logic [DATA_W-1:0] MAX_RESULT = 64'd6332659870762850625;

    typedef enum logic [1:0] {
        FUNC_FACT  = 2'd0,
        FUNC_DFACT = 2'd1,
        FUNC_PERM  = 2'd2,
        FUNC_COMB  = 2'd3
    } t_func;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_start;
        logic div_second;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic divide;
        logic two_div;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [DATA_W-1:0] fact(input logic [4:0] k);
        logic [DATA_W-1:0] v;
        case (k)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd1;
            5'd2:    v = 64'd2;
            5'd3:    v = 64'd6;
            5'd4:    v = 64'd24;
            5'd5:    v = 64'd120;
            5'd6:    v = 64'd720;
            5'd7:    v = 64'd5040;
            5'd8:    v = 64'd40320;
            5'd9:    v = 64'd362880;
            5'd10:   v = 64'd3628800;
            5'd11:   v = 64'd39916800;
            5'd12:   v = 64'd479001600;
            5'd13:   v = 64'd6227020800;
            5'd14:   v = 64'd87178291200;
            5'd15:   v = 64'd1307674368000;
            5'd16:   v = 64'd20922789888000;
            5'd17:   v = 64'd355687428096000;
            5'd18:   v = 64'd6402373705728000;
            5'd19:   v = 64'd121645100408832000;
            5'd20:   v = 64'd2432902008176640000;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] dfact(input logic [5:0] k);
        logic [DATA_W-1:0] v;
        case (k)
            6'd0:    v = 64'd1;
            6'd1:    v = 64'd1;
            6'd2:    v = 64'd2;
            6'd3:    v = 64'd3;
            6'd4:    v = 64'd8;
            6'd5:    v = 64'd15;
            6'd6:    v = 64'd48;
            6'd7:    v = 64'd105;
            6'd8:    v = 64'd384;
            6'd9:    v = 64'd945;
            6'd10:   v = 64'd3840;
            6'd11:   v = 64'd10395;
            6'd12:   v = 64'd46080;
            6'd13:   v = 64'd135135;
            6'd14:   v = 64'd645120;
            6'd15:   v = 64'd2027025;
            6'd16:   v = 64'd10321920;
            6'd17:   v = 64'd34459425;
            6'd18:   v = 64'd185794560;
            6'd19:   v = 64'd654729075;
            6'd20:   v = 64'd3715891200;
            6'd21:   v = 64'd13749310575;
            6'd22:   v = 64'd81749606400;
            6'd23:   v = 64'd316234143225;
            6'd24:   v = 64'd1961990553600;
            6'd25:   v = 64'd7905853580625;
            6'd26:   v = 64'd51011754393600;
            6'd27:   v = 64'd213458046676875;
            6'd28:   v = 64'd1428329123020800;
            6'd29:   v = 64'd6190283353629375;
            6'd30:   v = 64'd42849873690624000;
            6'd31:   v = 64'd191898783962510625;
            6'd32:   v = 64'd1371195958099968000;
            6'd33:   v = 64'd6332659870762850625;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/icu_req_if.sv =====
// request channel: operation selector and operands
interface icu_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic [icu_pkg::ARG_W-1:0]  m;
    logic [icu_pkg::ARG_W-1:0]  n;

    modport source (output valid, output func, output m, output n, input ready);
    modport sink   (input valid, input func, input m, input n, output ready);
endinterface

// ===== rtl/core/icu_rsp_if.sv =====
// response channel: exact result and error flag
interface icu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [icu_pkg::DATA_W-1:0] value;
    logic                       error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

// ===== rtl/core/integer_combinatorics_unit.sv =====
// Integer combinatorics unit: exact 64-bit n!, n!!, m!/(m-n)! and
// m!/((m-n)! n!) for 6-bit unsigned operands, one response per request.
// Results that cannot be formed exactly (n! with n > 20, n!! with n > 33,
// or the general permutation/combination path with n > m or m > 20) come
// back as all ones with error set. Factorials, double factorials and the
// trivial cases (m < 2, n = 0, n = 1, and for combinations n = m and
// n = m - 1) are decoded directly, with no division. The general paths run
// through one shared restoring divider that retires one quotient bit a
// cycle over 64 bits: permutation runs one 64-step division, combination
// two in sequence. One request is in work at a time; a finished response
// sits in its own output register, so the next request is taken while the
// previous response still waits.
module integer_combinatorics_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icu_req_if.sink     i_req,
    icu_rsp_if.source   o_rsp
);

    // command and status between controller and datapath
    icu_pkg::t_dp_cmd cmd;
    icu_pkg::t_dp_sts sts;

    // controller owns the request handshake and the sequencing
    icu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath holds operands, lookup tables, the divider and the output slot
    icu_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_func  (i_req.func),
        .i_m     (i_req.m),
        .i_n     (i_req.n),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_value (o_rsp.value),
        .o_error (o_rsp.error)
    );

endmodule

// ===== rtl/core/icu_dp.sv =====
// datapath: operand registers, case decode, restoring divider, output register
module icu_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  icu_pkg::t_dp_cmd           i_cmd,
    output icu_pkg::t_dp_sts           o_sts,
    input  logic [1:0]                 i_func,
    input  logic [icu_pkg::ARG_W-1:0]  i_m,
    input  logic [icu_pkg::ARG_W-1:0]  i_n,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [icu_pkg::DATA_W-1:0] o_value,
    output logic                       o_error
);

    localparam int DW = icu_pkg::DATA_W;
    localparam int AW = icu_pkg::ARG_W;

    icu_pkg::t_func             r_func;
    logic [AW-1:0]              r_m;
    logic [AW-1:0]              r_n;
    logic [DW-1:0]              r_res_value;
    logic                       r_res_error;
    logic [DW-1:0]              r_rem;
    logic [DW-1:0]              r_quo;
    logic [DW-1:0]              r_dvs;
    logic [icu_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_out_valid;
    logic [DW-1:0]              r_out_value;
    logic                       r_out_error;

    logic [DW-1:0]  direct_value;
    logic           direct_error;
    logic           divide;
    logic           m_lt2;
    logic           n_zero;
    logic           n_one;
    logic           n_eq_m;
    logic           n_eq_m1;
    logic           general_ok;
    logic [AW-1:0]  diff;
    logic [DW-1:0]  m_ext;
    logic [DW:0]    trial;
    logic [DW-1:0]  n_dividend;
    logic [DW-1:0]  n_divisor;
    logic           out_free;

    assign m_lt2      = (r_m < 6'd2);
    assign n_zero     = (r_n == '0);
    assign n_one      = (r_n == 6'd1);
    assign n_eq_m     = (r_n == r_m);
    assign n_eq_m1    = (r_n == (r_m - 6'd1));
    assign general_ok = (r_n <= r_m) && (r_m <= icu_pkg::MAX_FACTORIAL_ARG);
    assign diff       = r_m - r_n;
    assign m_ext      = {{(DW-AW){1'b0}}, r_m};

    always_comb begin
        direct_value = '1;
        direct_error = 1'b1;
        divide       = 1'b0;
        case (r_func)
            icu_pkg::FUNC_FACT: begin
                if (r_n <= icu_pkg::MAX_FACTORIAL_ARG) begin
                    direct_value = icu_pkg::fact(r_n[4:0]);
                    direct_error = 1'b0;
                end
            end
            icu_pkg::FUNC_DFACT: begin
                if (r_n <= icu_pkg::MAX_DOUBLE_FACTORIAL_ARG) begin
                    direct_value = icu_pkg::dfact(r_n);
                    direct_error = 1'b0;
                end
            end
            icu_pkg::FUNC_PERM: begin
                if (m_lt2 || n_zero) begin
                    direct_value = 64'd1;
                    direct_error = 1'b0;
                end else if (n_one) begin
                    direct_value = m_ext;
                    direct_error = 1'b0;
                end else if (general_ok) begin
                    divide = 1'b1;
                end
            end
            icu_pkg::FUNC_COMB: begin
                if (m_lt2 || n_zero || n_eq_m) begin
                    direct_value = 64'd1;
                    direct_error = 1'b0;
                end else if (n_one || n_eq_m1) begin
                    direct_value = m_ext;
                    direct_error = 1'b0;
                end else if (general_ok) begin
                    divide = 1'b1;
                end
            end
            default: begin
                divide = 1'b0;
            end
        endcase
    end

    // one restoring step: shift in next dividend bit, try subtract
    assign trial = {r_rem, r_quo[DW-1]} - {1'b0, r_dvs};

    // first pass m! / (m-n)!, second pass that quotient / n!
    assign n_dividend = i_cmd.div_second ? r_quo : icu_pkg::fact(r_m[4:0]);
    assign n_divisor  = i_cmd.div_second ? icu_pkg::fact(r_n[4:0])
                                         : icu_pkg::fact(diff[4:0]);

    assign out_free = !r_out_valid || i_ready;

    assign o_sts.divide   = divide;
    assign o_sts.two_div  = (r_func == icu_pkg::FUNC_COMB);
    assign o_sts.div_last = (r_cnt == {icu_pkg::CNT_W{1'b1}});
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= icu_pkg::t_func'(i_func);
            r_m    <= i_m;
            r_n    <= i_n;
        end
        if (i_cmd.eval) begin
            r_res_value <= direct_value;
            r_res_error <= direct_error;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= n_dividend;
            r_dvs <= n_divisor;
        end else if (i_cmd.div_step) begin
            if (!trial[DW]) begin
                r_rem <= trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_out_value <= divide ? r_quo : r_res_value;
            r_out_error <= divide ? 1'b0 : r_res_error;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

endmodule

// ===== rtl/core/icu_ctrl.sv =====
// controller: sequences capture, decode, divisions and result hand-off
module icu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  icu_pkg::t_dp_sts  i_sts,
    output icu_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV1,
        S_MID,
        S_DIV2,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                    n_ready       = 1'b0;
                end else begin
                    // ready rises in the cycle after reset is released
                    n_ready = 1'b1;
                end
            end
            S_EVAL: begin
                if (i_sts.divide) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV1;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = i_sts.two_div ? S_MID : S_DONE;
                end
            end
            S_MID: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_second = 1'b1;
                n_state          = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                    n_ready        = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

// ===== rtl/core/icu_port_checker.sv =====
// port-level assertions for the integer combinatorics unit, with bind
`include "integer_combinatorics_unit_assert.svh"

module icu_port_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [icu_pkg::DATA_W-1:0] i_rsp_value,
    input logic                       i_rsp_error
);

    // one request in work at a time
    `ICU_ASSERT_NXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready, "ready after accept")

    // error responses carry all ones
    `ICU_ASSERT_IMP(a_err_ones, i_rsp_valid && i_rsp_error, i_rsp_value == '1, "error value not ones")

    // every exact result is at least one and at most 33!!
    `ICU_ASSERT_IMP(a_ok_range, i_rsp_valid && !i_rsp_error, (i_rsp_value != '0) && (i_rsp_value <= icu_pkg::MAX_RESULT), "result out of range")

    // stalled response holds
    `ICU_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_error), "stalled response changed")

endmodule

bind integer_combinatorics_unit icu_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.value),
    .i_rsp_error (o_rsp.error)
);

// ===== test/testbench.sv =====
// testbench of the integer combinatorics unit: directed table and random transactions
`timescale 1ns / 1ps

module testbench;
    import icu_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 11;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          TAIL_CYCLES  = 140;
    localparam int          CYCLE_LIMIT  = 900000;
    localparam int          IDLE_PCT     = 38;
    localparam int          HOLD_AT      = 200;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          CALM_FIRST   = 400;
    localparam int          CALM_LAST    = 520;
    localparam logic [63:0] ALL_ONES     = '1;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              error;
    } t_outcome;

    typedef struct packed {
        t_func            op;
        logic [ARG_W-1:0] m;
        logic [ARG_W-1:0] n;
        logic             typed;
        t_outcome         want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    icu_req_if req_bus ();
    icu_rsp_if rsp_bus ();

    integer_combinatorics_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_outcome  offered_result;
    t_outcome  expected_results[$];
    t_stim_row directed_rows[$];
    int        fail_count;
    int        results_seen;
    int        cycle_count;
    int        hold_left;
    bit        hold_done;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // exact result computed by products of the operands, no lookup table
    function automatic t_outcome predict_combinatorics(input t_func op,
                                                       input logic [ARG_W-1:0] m,
                                                       input logic [ARG_W-1:0] n);
        t_outcome    res;
        logic [63:0] prod;
        logic [63:0] n_fact;
        int          k;
        res.value = ALL_ONES;
        res.error = 1'b1;
        prod      = 64'd1;
        n_fact    = 64'd1;
        case (op)
            FUNC_FACT: begin
                if (n <= MAX_FACTORIAL_ARG) begin
                    for (k = 2; k <= int'(n); k++) prod = prod * 64'(k);
                    res = '{prod, 1'b0};
                end
            end
            FUNC_DFACT: begin
                if (n <= MAX_DOUBLE_FACTORIAL_ARG) begin
                    for (k = int'(n); k >= 2; k -= 2) prod = prod * 64'(k);
                    res = '{prod, 1'b0};
                end
            end
            FUNC_PERM: begin
                if (m < 2 || n == 0) begin
                    res = '{64'd1, 1'b0};
                end else if (n == 1) begin
                    res = '{64'(m), 1'b0};
                end else if (n <= m && m <= MAX_FACTORIAL_ARG) begin
                    for (k = int'(m) - int'(n) + 1; k <= int'(m); k++) prod = prod * 64'(k);
                    res = '{prod, 1'b0};
                end
            end
            default: begin
                if (m < 2 || n == 0 || n == m) begin
                    res = '{64'd1, 1'b0};
                end else if (n == 1 || n == m - 1) begin
                    res = '{64'(m), 1'b0};
                end else if (n <= m && m <= MAX_FACTORIAL_ARG) begin
                    for (k = int'(m) - int'(n) + 1; k <= int'(m); k++) prod = prod * 64'(k);
                    for (k = 2; k <= int'(n); k++) n_fact = n_fact * 64'(k);
                    res = '{prod / n_fact, 1'b0};
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_stim_row stim_row(input t_func op, input int m, input int n,
                                           input logic typed, input logic [63:0] value,
                                           input logic error);
        t_stim_row row;
        row.op         = op;
        row.m          = ARG_W'(m);
        row.n          = ARG_W'(n);
        row.typed      = typed;
        row.want.value = value;
        row.want.error = error;
        return row;
    endfunction

    // offer one transaction, with random idle cycles first unless in a calm stretch
    task automatic offer_request(input t_func op, input logic [ARG_W-1:0] m,
                                 input logic [ARG_W-1:0] n, input t_outcome want,
                                 input bit calm);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.func   <= op;
        req_bus.m      <= m;
        req_bus.n      <= n;
        offered_result <= want;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // sender
    initial begin
        t_stim_row        row;
        t_func            op;
        logic [ARG_W-1:0] m;
        logic [ARG_W-1:0] n;
        int               pick;
        i_rst_n        <= 1'b0;
        req_bus.valid  <= 1'b0;
        req_bus.func   <= FUNC_FACT;
        req_bus.m      <= '0;
        req_bus.n      <= '0;
        offered_result <= '0;

        directed_rows.push_back(stim_row(FUNC_FACT,   0,  0, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_FACT,  63,  1, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_FACT,  63, 12, 1, 64'd479001600, 0));
        directed_rows.push_back(stim_row(FUNC_FACT,   0, 20, 1, 64'd2432902008176640000, 0));
        directed_rows.push_back(stim_row(FUNC_FACT,   0, 21, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_FACT,  63, 63, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_DFACT, 63,  0, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_DFACT,  0, 33, 1, 64'd6332659870762850625, 0));
        directed_rows.push_back(stim_row(FUNC_DFACT,  0, 34, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_DFACT, 63, 63, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_DFACT,  5, 17, 0, '0, 0));
        directed_rows.push_back(stim_row(FUNC_PERM,   1, 63, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_PERM,  63,  0, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_PERM,  63,  1, 1, 64'd63, 0));
        directed_rows.push_back(stim_row(FUNC_PERM,   5,  6, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_PERM,  21, 21, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_PERM,  21, 20, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_PERM,  20, 20, 0, '0, 0));
        directed_rows.push_back(stim_row(FUNC_PERM,  20, 19, 0, '0, 0));
        directed_rows.push_back(stim_row(FUNC_COMB,   0,  0, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_COMB,  63, 63, 1, 64'd1, 0));
        directed_rows.push_back(stim_row(FUNC_COMB,  63, 62, 1, 64'd63, 0));
        directed_rows.push_back(stim_row(FUNC_COMB,  40, 50, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_COMB,  21, 10, 1, ALL_ONES, 1));
        directed_rows.push_back(stim_row(FUNC_COMB,  20, 10, 0, '0, 0));
        directed_rows.push_back(stim_row(FUNC_COMB,  12,  5, 0, '0, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_request(row.op, row.m, row.n,
                          row.typed ? row.want : predict_combinatorics(row.op, row.m, row.n),
                          1'b0);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            op   = t_func'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 80) begin
                // mostly inside the exact range, with the borders just around it
                m = ARG_W'($urandom_range(22));
                case (op)
                    FUNC_FACT:  n = ARG_W'($urandom_range(22));
                    FUNC_DFACT: n = ARG_W'($urandom_range(35));
                    default:    n = ARG_W'($urandom_range(int'(m) + 1));
                endcase
                if (op == FUNC_FACT || op == FUNC_DFACT) m = ARG_W'($urandom_range(63));
            end else begin
                m = ARG_W'($urandom_range(63));
                n = ARG_W'($urandom_range(63));
            end
            offer_request(op, m, n, predict_combinatorics(op, m, n),
                          i >= CALM_FIRST && i < CALM_LAST);
        end
        req_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off, and a calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            rsp_bus.ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                             ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // record accepted requests and check accepted responses
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) expected_results.push_back(offered_result);
            if (rsp_bus.valid && rsp_bus.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual value %h error %b",
                             $time, rsp_bus.value, rsp_bus.error);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_bus.value !== want.value) begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want.value, rsp_bus.value);
                        fail_count++;
                    end
                    if (rsp_bus.error !== want.error) begin
                        $display("%0t: error flag mismatch, expected %b, actual %b",
                                 $time, want.error, rsp_bus.error);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        fail_count   = 0;
        results_seen = 0;
        cycle_count  = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/icu_pkg.sv
rtl/core/icu_req_if.sv
rtl/core/icu_rsp_if.sv
rtl/core/icu_dp.sv
rtl/core/icu_ctrl.sv
rtl/core/integer_combinatorics_unit.sv
rtl/core/icu_port_checker.sv
test/testbench.sv
